FILE: design/cnr_pkg.sv
// ----------------------------------------------------------------------------
// cnr_pkg
// Shared widths, constants and the stage record of the RGBA8 color converter.
// ----------------------------------------------------------------------------
package cnr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int INT_BITS   = 8;
    localparam int COMP_W     = INT_BITS + FRAC_BITS + 1;
    localparam int MAG_W      = COMP_W - 1;
    localparam int BYTE_W     = 8;
    localparam int NUM_W      = MAG_W + BYTE_W;
    localparam int NUM_COMP   = 4;
    localparam int NUM_CH     = 3;
    localparam int NUM_CELLS  = BYTE_W;
    localparam int FULL_SCALE = (1 << BYTE_W) - 1;
    localparam int ONE_INT    = 1 << FRAC_BITS;
    localparam int IN_TDATA_W = ((NUM_COMP * COMP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = NUM_COMP * BYTE_W;

    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0]  rem;
        logic [MAG_W-1:0]              den;
        logic [NUM_CH-1:0][BYTE_W-1:0] quo;
        logic [BYTE_W-1:0]             alpha;
        logic                          rescaled;
    } t_cell_data;

endpackage

FILE: design/cnr_front.sv
// ----------------------------------------------------------------------------
// cnr_front
// Input stage: range test, color maximum, alpha byte and divider setup.
// ----------------------------------------------------------------------------
module cnr_front
    import cnr_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [NUM_COMP-1:0][COMP_W-1:0]  i_comp,
    output logic                             o_valid,
    input  logic                             i_ready,
    output t_cell_data                       o_data
);

    localparam logic signed [COMP_W-1:0] ONE_VAL = COMP_W'(ONE_INT);

    logic                     r_valid;
    t_cell_data               r_data;
    t_cell_data               n_data;
    logic signed [COMP_W-1:0] w_c [NUM_COMP];
    logic signed [COMP_W-1:0] w_max;
    logic signed [COMP_W-1:0] w_max_rg;
    logic                     w_over;
    logic [NUM_W-1:0]         w_prod [NUM_COMP];
    logic [NUM_W-1:0]         w_alpha_sh;

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            w_c[k]    = i_comp[k];
            w_prod[k] = (NUM_W'(w_c[k][MAG_W-1:0]) << BYTE_W) - NUM_W'(w_c[k][MAG_W-1:0]);
        end
        w_over   = (w_c[0] > ONE_VAL) || (w_c[1] > ONE_VAL) ||
                   (w_c[2] > ONE_VAL) || (w_c[3] > ONE_VAL);
        w_max_rg = (w_c[1] > w_c[0]) ? w_c[1] : w_c[0];
        w_max    = (w_c[2] > w_max_rg) ? w_c[2] : w_max_rg;
    end

    always_comb begin
        w_alpha_sh = w_prod[3] >> FRAC_BITS;
        if (w_c[3] <= 0) begin
            n_data.alpha = '0;
        end else if (w_alpha_sh > NUM_W'(FULL_SCALE)) begin
            n_data.alpha = BYTE_W'(FULL_SCALE);
        end else begin
            n_data.alpha = w_alpha_sh[BYTE_W-1:0];
        end
        n_data.rescaled = w_over;
        n_data.quo      = '0;
        if (!w_over) begin
            n_data.den = MAG_W'(ONE_INT);
        end else if (w_max > 0) begin
            n_data.den = w_max[MAG_W-1:0];
        end else begin
            n_data.den = MAG_W'(1);
        end
        for (int k = 0; k < NUM_CH; k++) begin
            if (w_over && (w_max == 0)) begin
                n_data.rem[k] = '0;
            end else if (w_over && (w_max < 0)) begin
                n_data.rem[k] = NUM_W'(FULL_SCALE);
            end else if (w_c[k][COMP_W-1]) begin
                n_data.rem[k] = '0;
            end else begin
                n_data.rem[k] = w_prod[k];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/cnr_cell.sv
// ----------------------------------------------------------------------------
// cnr_cell
// Division cell: one restoring quotient bit for each color lane.
// ----------------------------------------------------------------------------
module cnr_cell
    import cnr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cell_data i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    logic             r_valid;
    t_cell_data       r_data;
    t_cell_data       n_data;
    logic [NUM_W-1:0] w_div;
    logic [NUM_W-1:0] w_diff;
    logic             w_ge;

    always_comb begin
        n_data = i_data;
        w_div  = NUM_W'({i_data.den, 7'b0});
        w_diff = '0;
        w_ge   = 1'b0;
        for (int k = 0; k < NUM_CH; k++) begin
            w_ge          = i_data.rem[k] >= w_div;
            w_diff        = w_ge ? (i_data.rem[k] - w_div) : i_data.rem[k];
            n_data.rem[k] = {w_diff[NUM_W-2:0], 1'b0};
            n_data.quo[k] = {i_data.quo[k][BYTE_W-2:0], w_ge};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/color_normalize_to_rgba8.sv
// ----------------------------------------------------------------------------
// color_normalize_to_rgba8
// HDR RGBA (signed Q8.16) to four 8-bit channels, max-normalized if any > 1.0.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock while the output side is not stalled:
// one input stage sets up the range test, the color maximum and the alpha
// byte, then a row of eight division cells yields one quotient bit per cycle
// for red, green and blue together. Each stage holds its item while the next
// one is full and cannot pass its own item on, so a stalled output holds at
// most nine pixels in flight.
module color_normalize_to_rgba8
    import cnr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // red_in[24:0], green_in[49:25], blue_in[74:50], alpha_in[99:75], zero pad
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // was_rescaled[0]
    output logic                    m_axis_tuser
);

    logic [NUM_COMP-1:0][COMP_W-1:0] w_comp;
    logic                            w_valid [NUM_CELLS+1];
    logic                            w_ready [NUM_CELLS+1];
    t_cell_data                      w_data  [NUM_CELLS+1];
    t_cell_data                      w_out;
    logic [NUM_W-1:0]                w_den_x256;

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            w_comp[k] = s_axis_tdata[k*COMP_W +: COMP_W];
        end
    end

    cnr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_comp  (w_comp),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cnr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign w_ready[NUM_CELLS] = m_axis_tready;
    assign w_out              = w_data[NUM_CELLS];
    assign m_axis_tvalid      = w_valid[NUM_CELLS];
    assign m_axis_tdata       = {w_out.alpha, w_out.quo[2], w_out.quo[1], w_out.quo[0]};
    assign m_axis_tuser       = w_out.rescaled;
    assign w_den_x256         = {w_data[0].den, 8'b0};

`ifndef ASSERT_OFF
    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    a_quotient_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] |-> (w_data[0].rem[0] < w_den_x256) &&
                       (w_data[0].rem[1] < w_den_x256) &&
                       (w_data[0].rem[2] < w_den_x256))
        else $error("color quotient would exceed one byte");

    a_inrange_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[0] && !w_data[0].rescaled) |-> (w_data[0].den == MAG_W'(ONE_INT)))
        else $error("in-range pixel not divided by unity");
`endif

endmodule

FILE: verif/color_normalize_to_rgba8_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_normalize_to_rgba8_test
// Self-checking regression for the HDR RGBA to RGBA8 color converter.
// ----------------------------------------------------------------------------
// Pixels go in on the slave stream and an in-bench predictor works out the
// four bytes and the rescale flag of each accepted request. Results on the
// master stream are checked in order against the oldest prediction. Both
// sides idle at random. One phase holds off the output long enough to stall
// the input, another pauses the input until everything has come back, and
// one runs both sides with no idling.
// ----------------------------------------------------------------------------
module color_normalize_to_rgba8_test;
    import cnr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic              rescaled;
    } t_rgba8_bytes;

    typedef logic signed [COMP_W-1:0] t_comp;

    localparam int    COMP_MAX = (1 << (COMP_W - 1)) - 1;
    localparam int    COMP_MIN = -(1 << (COMP_W - 1));
    localparam int    ONE      = ONE_INT;
    localparam int    RX_HOLD_CYCLES = 150;
    localparam int    LIMIT_CYCLES   = 300000;
    localparam int    MAX_REPORTS    = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    t_rgba8_bytes pending_pixels[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           tx_max_gap = 8;
    int           rx_max_stall = 8;
    bit           rx_hold_req = 1'b0;

    color_normalize_to_rgba8 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("color_normalize_to_rgba8 regression: fail");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] scale_to_byte(input longint comp, input longint den);
        longint q;
        q = (comp * FULL_SCALE) / den;
        if (q < 0)
            return '0;
        if (q > FULL_SCALE)
            return BYTE_W'(FULL_SCALE);
        return BYTE_W'(q);
    endfunction

    function automatic t_rgba8_bytes predict_rgba8(input t_comp r, input t_comp g,
                                                   input t_comp b, input t_comp a);
        longint       rv, gv, bv, av, peak, one_l;
        t_rgba8_bytes res;
        rv = longint'(r);
        gv = longint'(g);
        bv = longint'(b);
        av = longint'(a);
        one_l = longint'(ONE);
        res.rescaled = (rv > one_l) || (gv > one_l) || (bv > one_l) || (av > one_l);
        if (res.rescaled) begin
            peak = rv;
            if (gv > peak)
                peak = gv;
            if (bv > peak)
                peak = bv;
            if (peak == 0) begin
                res.red   = '0;
                res.green = '0;
                res.blue  = '0;
            end else begin
                res.red   = scale_to_byte(rv, peak);
                res.green = scale_to_byte(gv, peak);
                res.blue  = scale_to_byte(bv, peak);
            end
        end else begin
            res.red   = scale_to_byte(rv, one_l);
            res.green = scale_to_byte(gv, one_l);
            res.blue  = scale_to_byte(bv, one_l);
        end
        res.alpha = scale_to_byte(av, one_l);
        return res;
    endfunction

    function automatic int rand_comp();
        int v;
        case ($urandom_range(0, 5))
            0: v = int'($urandom);
            1: v = int'($urandom_range(0, 2 * ONE)) - ONE;
            2: v = ONE + int'($urandom_range(0, 4)) - 2;
            3: v = int'($urandom_range(ONE + 1, 8 * ONE));
            4: v = int'($urandom_range(0, 1023)) - 512;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = COMP_MAX;
                    1: v = COMP_MIN;
                    2: v = 0;
                    3: v = ONE;
                    default: v = -ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic int rand_in_range();
        int v;
        v = int'($urandom_range(0, ONE + ONE / 4)) - ONE / 4;
        return v;
    endfunction

    task automatic send_pixel(input int r, input int g, input int b, input int a);
        int    gap;
        t_comp rc, gc, bc, ac;
        rc  = t_comp'(r);
        gc  = t_comp'(g);
        bc  = t_comp'(b);
        ac  = t_comp'(a);
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_data  <= {{(IN_TDATA_W - NUM_COMP * COMP_W){1'b0}}, ac, bc, gc, rc};
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_pixels.push_back(predict_rgba8(rc, gc, bc, ac));
    endtask

    task automatic send_random_pixel();
        if ($urandom_range(0, 2) == 0)
            send_pixel(rand_in_range(), rand_in_range(), rand_in_range(), rand_in_range());
        else
            send_pixel(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    // check each result against the oldest prediction
    always @(posedge i_clk) begin
        t_rgba8_bytes got, want;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tdata[31:24], m_axis_tuser};
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result r=%0d g=%0d b=%0d a=%0d rescaled=%0b",
                             got.red, got.green, got.blue, got.alpha, got.rescaled);
            end else begin
                want = pending_pixels.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d rescaled=%0b,",
                                  " got r=%0d g=%0d b=%0d a=%0d rescaled=%0b"},
                                 want.red, want.green, want.blue, want.alpha,
                                 want.rescaled, got.red, got.green, got.blue, got.alpha,
                                 got.rescaled);
                end
            end
        end
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        forever begin
            stall = rx_hold_req ? RX_HOLD_CYCLES : $urandom_range(0, rx_max_stall);
            rx_hold_req = 1'b0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid && !rx_hold_req);
        end
    end

    task automatic test_directed();
        send_pixel(0, 0, 0, 0);
        send_pixel(ONE, ONE, ONE, ONE);
        send_pixel(ONE + 1, ONE, 0, ONE);
        send_pixel(0, 0, 0, ONE + 1);
        send_pixel(0, -ONE, 0, ONE + 1);
        send_pixel(-5, -ONE, -3, 2 * ONE);
        send_pixel(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        send_pixel(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        send_pixel(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MAX);
        send_pixel(COMP_MAX, COMP_MIN, ONE / 2, 0);
        send_pixel(ONE / 2, ONE / 4, 3 * ONE / 4, ONE / 2);
        send_pixel(1, -1, 257, ONE - 1);
        send_pixel(2 * ONE, ONE, ONE / 2, COMP_MIN);
        send_pixel(ONE, 3 * ONE, 2 * ONE, 0);
        send_pixel(ONE, ONE, 4 * ONE, ONE);
        send_pixel(ONE + 1, ONE + 1, ONE + 1, COMP_MAX);
        send_pixel(-ONE, ONE, 5 * ONE, -1);
        send_pixel(COMP_MAX, 1, -1, 0);
        send_pixel(-ONE, -ONE, -ONE, -ONE);
        send_pixel(ONE - 1, ONE - 1, ONE - 1, ONE + 1);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_pixel();
    endtask

    task automatic test_back_pressure();
        tx_max_gap = 0;
        rx_hold_req = 1'b1;
        repeat (60) send_random_pixel();
        tx_max_gap = 8;
    endtask

    task automatic test_drain_pause();
        repeat (40) send_random_pixel();
        wait_drained();
        repeat (40) send_random_pixel();
    endtask

    task automatic test_streaming();
        tx_max_gap = 0;
        rx_max_stall = 0;
        repeat (100) send_random_pixel();
        tx_max_gap = 8;
        rx_max_stall = 8;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500);
        test_back_pressure();
        test_random(300);
        test_drain_pause();
        test_streaming();
        test_random(300);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("color_normalize_to_rgba8 regression: pass");
        else
            $display("color_normalize_to_rgba8 regression: fail");
        $finish;
    end

endmodule
